@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define ASSERT_ON(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion on the block clock and reset.
`define ASSERT_CLK(label, prop) `ASSERT_ON(label, clock, reset, prop)

`endif

@@ src/parm_pkg.sv @@
// Package with the constants, types and states of the prototype matrix.
package parm_pkg;

   localparam int DIM = 64;
   localparam int ENTRIES = 256;
   localparam int DIM_W = $clog2(DIM);
   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int CNT_W = 16;
   localparam int STAMP_W = 40;
   localparam int META_W = CNT_W + STAMP_W;
   localparam int ACC_W = 31 + DIM_W;
   localparam int DOT_W = ACC_W + 1;

   localparam logic [3:0] CSR_ADD_THRESHOLD = 4'd0;
   localparam logic [3:0] CSR_MAX_ENTRIES = 4'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_QROOT,
      ST_QROOT_WAIT,
      ST_SCAN,
      ST_SCAN_END,
      ST_SIM,
      ST_PROOT_WAIT,
      ST_DIV_T,
      ST_DIV_S,
      ST_SIM_CMP,
      ST_DECIDE,
      ST_STAMP,
      ST_STAMP_END,
      ST_ADD,
      ST_ADD_END,
      ST_META_RD,
      ST_REF_CNT,
      ST_REF_RD,
      ST_REF_DIV0,
      ST_REF_DIV,
      ST_RROOT,
      ST_RROOT_WAIT,
      ST_NORM_RD,
      ST_NORM_DIV0,
      ST_NORM_DIV,
      ST_ZERO,
      ST_META_WR
   } state_type;

endpackage

@@ src/parm_div.sv @@
// Restoring divider producing one quotient bit per cycle.
module parm_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [63:0]             num,
   input  logic [63:0]             den,
   output parm_pkg::unit_stat_type stat,
   output logic [63:0]             quo
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [64:0] rem_sh;
   logic [64:0] diff;
   logic        ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[63]};
      diff = rem_sh - {1'b0, den_ff};
      ge = rem_sh >= {1'b0, den_ff};
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = num;
         rem_in = '0;
         den_in = den;
      end else if (run_ff) begin
         quo_in = {quo_ff[62:0], ge};
         rem_in = ge ? diff[63:0] : rem_sh[63:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign quo = quo_ff;

endmodule

@@ src/parm_sqrt.sv @@
// Floor square root of a 64-bit value, one root bit per cycle.
module parm_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [63:0]             arg,
   output parm_pkg::unit_stat_type stat,
   output logic [31:0]             root
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] arg_ff, arg_in;
   logic [31:0] root_ff, root_in;
   logic [33:0] rem_ff, rem_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic [35:0] diff;

   always_comb begin
      rem_sh = {rem_ff, arg_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      diff = rem_sh - trial;
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      arg_in = arg_ff;
      root_in = root_ff;
      rem_in = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         arg_in = arg;
         root_in = '0;
         rem_in = '0;
      end else if (run_ff) begin
         arg_in = {arg_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in = diff[33:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      arg_ff <= arg_in;
      root_ff <= root_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign root = root_ff;

endmodule

@@ src/prototype_add_or_refine_matrix.sv @@
// Top level of the prototype matrix: query buffer, prototype store and sequencer.
//
// A query vector enters one element per transfer on the req_ channel: a transfer
// takes place at a rising edge with start high and busy low. While a query is
// being collected, busy stays low and each cycle with start high takes an element.
// The element with req_last high, or the 64th element, completes the query;
// req_stamp and req_now are sampled with it, and busy rises on the next cycle.
// The block then compares the query with every stored prototype, decides to add
// or refine, and emits the resulting prototype as 64 rsp_ transfers, each shown
// for one cycle with rsp_strobe high; rsp_final_res marks the last. The receiver
// cannot hold results off. busy falls once the store has been updated.
// Search takes one square root of a nonzero query norm, then for each entry one pass
// through the prototype memory and, when both norms are nonzero, a square root
// and two divides. Adding writes the query into a slot, after a stamp search for
// the oldest entry at the limit; refining uses the shared divider twice per element.
// Configuration transfers on csr_ are always accepted and take effect at once.
// Reset empties the store and the query; no clearing pass is needed.
`include "assert_macros.svh"

module prototype_add_or_refine_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_element,
   input  logic               req_last,
   input  logic [39:0]        req_stamp,
   input  logic [39:0]        req_now,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_proto_element,
   output logic               rsp_final_res,
   output logic               rsp_action,
   output logic [7:0]         rsp_slot,
   output logic [16:0]        rsp_residual,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [16:0]        csr_data
);

   localparam int DIM_W = parm_pkg::DIM_W;
   localparam int SLOT_W = parm_pkg::SLOT_W;
   localparam int ACC_W = parm_pkg::ACC_W;
   localparam int DOT_W = parm_pkg::DOT_W;
   localparam int META_W = parm_pkg::META_W;
   localparam int STAMP_W = parm_pkg::STAMP_W;
   localparam int CNT_W = parm_pkg::CNT_W;
   localparam logic [DIM_W:0] LAST_IDX = (DIM_W + 1)'(parm_pkg::DIM - 1);
   localparam logic [SLOT_W:0] FULL = (SLOT_W + 1)'(parm_pkg::ENTRIES);

   parm_pkg::state_type state_ff, state_in;

   logic [DIM_W-1:0]         idx_ff, idx_in;
   logic [DIM_W:0]           qlen_ff, qlen_in;
   logic [ACC_W-1:0]         nq_ff, nq_in;
   logic [STAMP_W-1:0]       stamp_ff, stamp_in;
   logic [STAMP_W-1:0]       now_ff, now_in;
   logic [SLOT_W:0]          used_ff, used_in;
   logic [16:0]              thr_ff, thr_in;
   logic [8:0]               maxe_ff, maxe_in;
   logic [31:0]              rq_ff, rq_in;
   logic [31:0]              rp_ff, rp_in;
   logic [SLOT_W:0]          j_ff, j_in;
   logic [SLOT_W-1:0]        jd_ff, jd_in;
   logic [DIM_W:0]           i_ff, i_in;
   logic                     rdv_ff, rdv_in;
   logic [DIM_W-1:0]         ridx_ff, ridx_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [ACC_W-1:0]         np_ff, np_in;
   logic signed [17:0]       sim_ff, sim_in;
   logic signed [17:0]       best_ff, best_in;
   logic [SLOT_W-1:0]        bslot_ff, bslot_in;
   logic [16:0]              res_ff, res_in;
   logic                     act_ff, act_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [STAMP_W-1:0]       oldest_ff, oldest_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [ACC_W-1:0]         na_ff, na_in;
   logic [31:0]              rr_ff, rr_in;
   logic                     sgn_ff, sgn_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic                     rsp_final_ff, rsp_final_in;
   logic signed [15:0]       rsp_elem_ff, rsp_elem_in;

   logic [15:0]              pm_mem [parm_pkg::ENTRIES * parm_pkg::DIM];
   logic [16:0]              qb_mem [parm_pkg::DIM];
   logic [META_W-1:0]        mt_mem [parm_pkg::ENTRIES];
   logic [15:0]              pm_rdata_ff;
   logic [16:0]              qb_rdata_ff;
   logic [META_W-1:0]        mt_rdata_ff;
   logic [SLOT_W+DIM_W-1:0]  pm_raddr;
   logic [SLOT_W+DIM_W-1:0]  pm_waddr;
   logic [DIM_W-1:0]         qb_raddr;
   logic [DIM_W-1:0]         qb_waddr;
   logic [SLOT_W-1:0]        mt_raddr;
   logic                     pm_we;
   logic                     qb_we;
   logic                     mt_we;
   logic [15:0]              pm_wdata;
   logic [16:0]              qb_wdata;
   logic [META_W-1:0]        mt_wdata;

   logic                     dv_start;
   logic [63:0]              dv_num;
   logic [63:0]              dv_den;
   logic [63:0]              dv_quo;
   parm_pkg::unit_stat_type  dv_stat;
   logic                     sq_start;
   logic [63:0]              sq_arg;
   logic [31:0]              sq_root;
   parm_pkg::unit_stat_type  sq_stat;

   logic signed [31:0]       e_sq;
   logic signed [15:0]       q_use;
   logic signed [15:0]       p_val;
   logic signed [31:0]       qp;
   logic signed [31:0]       pp;
   logic signed [32:0]       pn;
   logic signed [33:0]       s_sum;
   logic [33:0]              s_neg;
   logic [32:0]              s_mag;
   logic [16:0]              d_val;
   logic [16:0]              m_val;
   logic [33:0]              mm;
   logic [16:0]              a_mag;
   logic [DOT_W-1:0]         dot_neg;
   logic [ACC_W-1:0]         dot_mag;
   logic signed [18:0]       res_full;
   logic [16:0]              res_now;
   logic [8:0]               lim;
   logic [15:0]              sat_o;

   parm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (dv_den),
      .stat  (dv_stat),
      .quo   (dv_quo)
   );

   parm_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .arg   (sq_arg),
      .stat  (sq_stat),
      .root  (sq_root)
   );

   always_ff @(posedge clock) begin
      if (pm_we) begin
         pm_mem[pm_waddr] <= pm_wdata;
      end
      pm_rdata_ff <= pm_mem[pm_raddr];
   end

   always_ff @(posedge clock) begin
      if (qb_we) begin
         qb_mem[qb_waddr] <= qb_wdata;
      end
      qb_rdata_ff <= qb_mem[qb_raddr];
   end

   always_ff @(posedge clock) begin
      if (mt_we) begin
         mt_mem[slot_ff] <= mt_wdata;
      end
      mt_rdata_ff <= mt_mem[mt_raddr];
   end

   always_comb begin
      e_sq = req_element * req_element;
      q_use = ({1'b0, ridx_ff} < qlen_ff) ? $signed(qb_rdata_ff[15:0]) : 16'sd0;
      p_val = $signed(pm_rdata_ff);
      qp = q_use * p_val;
      pp = p_val * p_val;
      pn = p_val * $signed({1'b0, cnt_ff});
      s_sum = {pn[32], pn} + {{18{q_use[15]}}, q_use};
      s_neg = -s_sum;
      s_mag = s_sum[33] ? s_neg[32:0] : s_sum[32:0];
      d_val = {1'b0, cnt_ff} + 17'd1;
      m_val = dv_quo[16:0];
      mm = m_val * m_val;
      a_mag = qb_rdata_ff[16] ? (17'd0 - qb_rdata_ff) : qb_rdata_ff;
      dot_neg = -dot_ff;
      dot_mag = dot_ff[DOT_W-1] ? dot_neg[ACC_W-1:0] : dot_ff[ACC_W-1:0];
      res_full = 19'sd32768 - {best_ff[17], best_ff};
      res_now = (used_ff == '0) ? 17'd32768 : res_full[16:0];
      if (maxe_ff == 9'd0) begin
         lim = 9'd1;
      end else if ({1'b0, maxe_ff} > {1'b0, FULL}) begin
         lim = 9'(FULL);
      end else begin
         lim = maxe_ff;
      end
      if (sgn_ff) begin
         sat_o = (dv_quo > 64'd32768) ? 16'h8000 : (16'd0 - dv_quo[15:0]);
      end else begin
         sat_o = (dv_quo > 64'd32767) ? 16'h7FFF : dv_quo[15:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      qlen_in = qlen_ff;
      nq_in = nq_ff;
      stamp_in = stamp_ff;
      now_in = now_ff;
      used_in = used_ff;
      thr_in = thr_ff;
      maxe_in = maxe_ff;
      rq_in = rq_ff;
      rp_in = rp_ff;
      j_in = j_ff;
      jd_in = jd_ff;
      i_in = i_ff;
      rdv_in = 1'b0;
      ridx_in = ridx_ff;
      dot_in = dot_ff;
      np_in = np_ff;
      sim_in = sim_ff;
      best_in = best_ff;
      bslot_in = bslot_ff;
      res_in = res_ff;
      act_in = act_ff;
      slot_in = slot_ff;
      oldest_in = oldest_ff;
      cnt_in = cnt_ff;
      na_in = na_ff;
      rr_in = rr_ff;
      sgn_in = sgn_ff;
      rsp_strobe_in = 1'b0;
      rsp_final_in = 1'b0;
      rsp_elem_in = rsp_elem_ff;
      pm_raddr = {slot_ff, i_ff[DIM_W-1:0]};
      pm_waddr = {slot_ff, i_ff[DIM_W-1:0]};
      pm_we = 1'b0;
      pm_wdata = '0;
      qb_raddr = i_ff[DIM_W-1:0];
      qb_waddr = i_ff[DIM_W-1:0];
      qb_we = 1'b0;
      qb_wdata = '0;
      mt_raddr = slot_ff;
      mt_we = 1'b0;
      mt_wdata = '0;
      dv_start = 1'b0;
      dv_num = '0;
      dv_den = '0;
      sq_start = 1'b0;
      sq_arg = '0;

      if (csr_valid) begin
         priority case (csr_index)
            parm_pkg::CSR_ADD_THRESHOLD: thr_in = csr_data;
            parm_pkg::CSR_MAX_ENTRIES:   maxe_in = csr_data[8:0];
            default: ;
         endcase
      end

      if (rdv_ff && (state_ff == parm_pkg::ST_SCAN || state_ff == parm_pkg::ST_SCAN_END)) begin
         dot_in = dot_ff + {{(DOT_W - 32){qp[31]}}, qp};
         np_in = np_ff + {{(ACC_W - 31){1'b0}}, pp[30:0]};
      end
      if (rdv_ff && (state_ff == parm_pkg::ST_STAMP ||
                     state_ff == parm_pkg::ST_STAMP_END)) begin
         if (jd_ff == '0 || mt_rdata_ff[STAMP_W-1:0] < oldest_ff) begin
            oldest_in = mt_rdata_ff[STAMP_W-1:0];
            slot_in = jd_ff;
         end
      end
      if (rdv_ff && (state_ff == parm_pkg::ST_ADD || state_ff == parm_pkg::ST_ADD_END)) begin
         pm_waddr = {slot_ff, ridx_ff};
         pm_we = 1'b1;
         pm_wdata = q_use;
         rsp_strobe_in = 1'b1;
         rsp_final_in = {1'b0, ridx_ff} == LAST_IDX;
         rsp_elem_in = q_use;
      end

      unique case (state_ff)
         parm_pkg::ST_IDLE: begin
            if (start) begin
               qb_waddr = idx_ff;
               qb_we = 1'b1;
               qb_wdata = {req_element[15], req_element};
               nq_in = ((idx_ff == '0) ? '0 : nq_ff) + {{(ACC_W - 31){1'b0}}, e_sq[30:0]};
               if (req_last || {1'b0, idx_ff} == LAST_IDX) begin
                  qlen_in = {1'b0, idx_ff} + 1'b1;
                  idx_in = '0;
                  stamp_in = (req_stamp != '0) ? req_stamp : req_now;
                  now_in = req_now;
                  j_in = '0;
                  i_in = '0;
                  best_in = '0;
                  bslot_in = '0;
                  state_in = (used_ff == '0) ? parm_pkg::ST_DECIDE : parm_pkg::ST_QROOT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         parm_pkg::ST_QROOT: begin
            if (nq_ff == '0) begin
               state_in = parm_pkg::ST_SCAN;
            end else begin
               sq_start = 1'b1;
               sq_arg = {{(44 - ACC_W){1'b0}}, nq_ff, 20'd0};
               state_in = parm_pkg::ST_QROOT_WAIT;
            end
         end
         parm_pkg::ST_QROOT_WAIT: begin
            if (sq_stat.done) begin
               rq_in = sq_root;
               state_in = parm_pkg::ST_SCAN;
            end
         end
         parm_pkg::ST_SCAN: begin
            pm_raddr = {j_ff[SLOT_W-1:0], i_ff[DIM_W-1:0]};
            qb_raddr = i_ff[DIM_W-1:0];
            rdv_in = 1'b1;
            ridx_in = i_ff[DIM_W-1:0];
            if (i_ff == '0) begin
               dot_in = '0;
               np_in = '0;
            end
            if (i_ff == LAST_IDX) begin
               state_in = parm_pkg::ST_SCAN_END;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         parm_pkg::ST_SCAN_END: begin
            state_in = parm_pkg::ST_SIM;
         end
         parm_pkg::ST_SIM: begin
            if (nq_ff == '0 || np_ff == '0) begin
               sim_in = '0;
               state_in = parm_pkg::ST_SIM_CMP;
            end else begin
               sq_start = 1'b1;
               sq_arg = {{(44 - ACC_W){1'b0}}, np_ff, 20'd0};
               state_in = parm_pkg::ST_PROOT_WAIT;
            end
         end
         parm_pkg::ST_PROOT_WAIT: begin
            if (sq_stat.done) begin
               rp_in = sq_root;
               dv_start = 1'b1;
               dv_num = {{(44 - ACC_W){1'b0}}, dot_mag, 20'd0};
               dv_den = {32'd0, rq_ff};
               state_in = parm_pkg::ST_DIV_T;
            end
         end
         parm_pkg::ST_DIV_T: begin
            if (dv_stat.done) begin
               dv_start = 1'b1;
               dv_num = {dv_quo[48:0], 15'd0};
               dv_den = {32'd0, rp_ff};
               state_in = parm_pkg::ST_DIV_S;
            end
         end
         parm_pkg::ST_DIV_S: begin
            if (dv_stat.done) begin
               if (dv_quo > 64'd32768) begin
                  sim_in = dot_ff[DOT_W-1] ? -18'sd32768 : 18'sd32768;
               end else begin
                  sim_in = dot_ff[DOT_W-1] ? -$signed({1'b0, dv_quo[16:0]})
                                           : $signed({1'b0, dv_quo[16:0]});
               end
               state_in = parm_pkg::ST_SIM_CMP;
            end
         end
         parm_pkg::ST_SIM_CMP: begin
            if (j_ff == '0 || sim_ff > best_ff) begin
               best_in = sim_ff;
               bslot_in = j_ff[SLOT_W-1:0];
            end
            j_in = j_ff + 1'b1;
            i_in = '0;
            state_in = (j_ff + 1'b1 == used_ff) ? parm_pkg::ST_DECIDE : parm_pkg::ST_SCAN;
         end
         parm_pkg::ST_DECIDE: begin
            res_in = res_now;
            i_in = '0;
            j_in = '0;
            if (used_ff == '0 || res_now > thr_ff) begin
               act_in = 1'b0;
               if ({1'b0, used_ff} >= {1'b0, lim}) begin
                  state_in = parm_pkg::ST_STAMP;
               end else begin
                  slot_in = used_ff[SLOT_W-1:0];
                  used_in = used_ff + 1'b1;
                  state_in = parm_pkg::ST_ADD;
               end
            end else begin
               act_in = 1'b1;
               slot_in = bslot_ff;
               state_in = parm_pkg::ST_META_RD;
            end
         end
         parm_pkg::ST_STAMP: begin
            mt_raddr = j_ff[SLOT_W-1:0];
            rdv_in = 1'b1;
            jd_in = j_ff[SLOT_W-1:0];
            j_in = j_ff + 1'b1;
            if (j_ff + 1'b1 == used_ff) begin
               state_in = parm_pkg::ST_STAMP_END;
            end
         end
         parm_pkg::ST_STAMP_END: begin
            state_in = parm_pkg::ST_ADD;
         end
         parm_pkg::ST_ADD: begin
            qb_raddr = i_ff[DIM_W-1:0];
            rdv_in = 1'b1;
            ridx_in = i_ff[DIM_W-1:0];
            if (i_ff == LAST_IDX) begin
               state_in = parm_pkg::ST_ADD_END;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         parm_pkg::ST_ADD_END: begin
            mt_we = 1'b1;
            mt_wdata = {CNT_W'(1), stamp_ff};
            state_in = parm_pkg::ST_IDLE;
         end
         parm_pkg::ST_META_RD: begin
            mt_raddr = slot_ff;
            state_in = parm_pkg::ST_REF_CNT;
         end
         parm_pkg::ST_REF_CNT: begin
            cnt_in = mt_rdata_ff[META_W-1:STAMP_W];
            na_in = '0;
            i_in = '0;
            state_in = parm_pkg::ST_REF_RD;
         end
         parm_pkg::ST_REF_RD: begin
            ridx_in = i_ff[DIM_W-1:0];
            state_in = parm_pkg::ST_REF_DIV0;
         end
         parm_pkg::ST_REF_DIV0: begin
            sgn_in = s_sum[33];
            dv_start = 1'b1;
            dv_num = {30'd0, s_mag, 1'b0} + {47'd0, d_val};
            dv_den = {46'd0, d_val, 1'b0};
            state_in = parm_pkg::ST_REF_DIV;
         end
         parm_pkg::ST_REF_DIV: begin
            if (dv_stat.done) begin
               qb_we = 1'b1;
               qb_wdata = sgn_ff ? (17'd0 - m_val) : m_val;
               na_in = na_ff + {{(ACC_W - 31){1'b0}}, mm[30:0]};
               if (i_ff == LAST_IDX) begin
                  state_in = parm_pkg::ST_RROOT;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = parm_pkg::ST_REF_RD;
               end
            end
         end
         parm_pkg::ST_RROOT: begin
            i_in = '0;
            if (na_ff == '0) begin
               state_in = parm_pkg::ST_ZERO;
            end else begin
               sq_start = 1'b1;
               sq_arg = {{(44 - ACC_W){1'b0}}, na_ff, 20'd0};
               state_in = parm_pkg::ST_RROOT_WAIT;
            end
         end
         parm_pkg::ST_RROOT_WAIT: begin
            if (sq_stat.done) begin
               rr_in = sq_root;
               state_in = parm_pkg::ST_NORM_RD;
            end
         end
         parm_pkg::ST_NORM_RD: begin
            state_in = parm_pkg::ST_NORM_DIV0;
         end
         parm_pkg::ST_NORM_DIV0: begin
            sgn_in = qb_rdata_ff[16];
            dv_start = 1'b1;
            dv_num = {21'd0, a_mag, 26'd0} + {32'd0, rr_ff};
            dv_den = {31'd0, rr_ff, 1'b0};
            state_in = parm_pkg::ST_NORM_DIV;
         end
         parm_pkg::ST_NORM_DIV: begin
            if (dv_stat.done) begin
               pm_we = 1'b1;
               pm_wdata = sat_o;
               rsp_strobe_in = 1'b1;
               rsp_final_in = i_ff == LAST_IDX;
               rsp_elem_in = $signed(sat_o);
               if (i_ff == LAST_IDX) begin
                  state_in = parm_pkg::ST_META_WR;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = parm_pkg::ST_NORM_RD;
               end
            end
         end
         parm_pkg::ST_ZERO: begin
            pm_we = 1'b1;
            pm_wdata = '0;
            rsp_strobe_in = 1'b1;
            rsp_final_in = i_ff == LAST_IDX;
            rsp_elem_in = '0;
            if (i_ff == LAST_IDX) begin
               state_in = parm_pkg::ST_META_WR;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         parm_pkg::ST_META_WR: begin
            mt_we = 1'b1;
            mt_wdata = {(cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1, now_ff};
            state_in = parm_pkg::ST_IDLE;
         end
         default: state_in = parm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= parm_pkg::ST_IDLE;
         idx_ff <= '0;
         used_ff <= '0;
         thr_ff <= 17'd16384;
         maxe_ff <= 9'd256;
         rdv_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         used_ff <= used_in;
         thr_ff <= thr_in;
         maxe_ff <= maxe_in;
         rdv_ff <= rdv_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      qlen_ff <= qlen_in;
      nq_ff <= nq_in;
      stamp_ff <= stamp_in;
      now_ff <= now_in;
      rq_ff <= rq_in;
      rp_ff <= rp_in;
      j_ff <= j_in;
      jd_ff <= jd_in;
      i_ff <= i_in;
      ridx_ff <= ridx_in;
      dot_ff <= dot_in;
      np_ff <= np_in;
      sim_ff <= sim_in;
      best_ff <= best_in;
      bslot_ff <= bslot_in;
      res_ff <= res_in;
      act_ff <= act_in;
      slot_ff <= slot_in;
      oldest_ff <= oldest_in;
      cnt_ff <= cnt_in;
      na_ff <= na_in;
      rr_ff <= rr_in;
      sgn_ff <= sgn_in;
      rsp_final_ff <= rsp_final_in;
      rsp_elem_ff <= rsp_elem_in;
   end

   assign busy = state_ff != parm_pkg::ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_proto_element = rsp_elem_ff;
   assign rsp_final_res = rsp_final_ff;
   assign rsp_action = act_ff;
   assign rsp_slot = slot_ff;
   assign rsp_residual = res_ff;

   `ASSERT_CLK(a_used_bound, used_ff <= FULL)
   `ASSERT_CLK(a_write_used_slot, pm_we |-> ({1'b0, slot_ff} < used_ff))
   `ASSERT_CLK(a_div_free, dv_start |-> !dv_stat.busy)
   `ASSERT_CLK(a_sqrt_free, sq_start |-> !sq_stat.busy)

endmodule

@@ dv/tb_prototype_add_or_refine_matrix.sv @@
// Self-checking testbench for the prototype add-or-refine matrix.
`timescale 1ns / 1ps

module tb_prototype_add_or_refine_matrix;
   import parm_pkg::*;

   typedef struct {
      logic signed [15:0] element;
      logic               final_res;
      logic               action;
      logic [7:0]         slot;
      logic [16:0]        residual;
   } proto_word_t;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_element;
   logic               req_last;
   logic [39:0]        req_stamp;
   logic [39:0]        req_now;
   logic               rsp_strobe;
   logic signed [15:0] rsp_proto_element;
   logic               rsp_final_res;
   logic               rsp_action;
   logic [7:0]         rsp_slot;
   logic [16:0]        rsp_residual;
   logic               csr_valid;
   logic               csr_ready;
   logic [3:0]         csr_index;
   logic [16:0]        csr_data;

   logic signed [15:0] protos [ENTRIES][DIM];
   logic [15:0]        counts [ENTRIES];
   logic [39:0]        stamps [ENTRIES];
   logic signed [15:0] query [DIM];
   int                 used_cnt;
   int                 elem_pos;
   logic [16:0]        threshold;
   logic [8:0]         entry_limit;

   proto_word_t        proto_out_q[$];
   int                 mismatches;
   bit                 idle_on;
   int                 elements_sent;
   logic signed [15:0] bases [4][DIM];

   prototype_add_or_refine_matrix i_dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag(longint x);
      return x < 0 ? longint'(-x) : x;
   endfunction

   function automatic int cosine_to(int slot);
      longint          dot;
      longint unsigned nq, np, rq, rp, t, s;
      dot = 0;
      nq = 0;
      np = 0;
      for (int i = 0; i < DIM; i++) begin
         dot += longint'(query[i]) * longint'(protos[slot][i]);
         nq += longint'(query[i]) * longint'(query[i]);
         np += longint'(protos[slot][i]) * longint'(protos[slot][i]);
      end
      if (nq == 0 || np == 0) return 0;
      rq = int_sqrt(nq << 20);
      rp = int_sqrt(np << 20);
      t = (mag(dot) << 20) / rq;
      s = (t << 15) / rp;
      if (s > 32768) s = 32768;
      return dot < 0 ? -int'(s) : int'(s);
   endfunction

   function automatic void refine_slot(int slot);
      longint          avg [DIM];
      longint unsigned n, d, na, r, m, o;
      longint          s;
      n = counts[slot];
      d = n + 1;
      na = 0;
      for (int i = 0; i < DIM; i++) begin
         s = longint'(protos[slot][i]) * longint'(n) + longint'(query[i]);
         m = (2 * mag(s) + d) / (2 * d);
         avg[i] = s < 0 ? -longint'(m) : longint'(m);
         na += m * m;
      end
      if (na == 0) begin
         for (int i = 0; i < DIM; i++) protos[slot][i] = '0;
         return;
      end
      r = int_sqrt(na << 20);
      for (int i = 0; i < DIM; i++) begin
         m = mag(avg[i]);
         o = ((m << 26) + r) / (2 * r);
         if (avg[i] < 0) begin
            if (o > 32768) o = 32768;
            protos[slot][i] = -int'(o);
         end else begin
            if (o > 32767) o = 32767;
            protos[slot][i] = int'(o);
         end
      end
   endfunction

   function automatic void cluster_step(logic signed [15:0] e, logic last,
                                        logic [39:0] stamp, logic [39:0] now);
      int          idx, slot, best, s, lim;
      logic [16:0] resid;
      bit          add;
      logic [39:0] oldest;
      proto_word_t w;
      idx = elem_pos;
      slot = 0;
      best = 0;
      if (idx >= DIM) idx = 0;
      if (idx == 0) for (int i = 0; i < DIM; i++) query[i] = '0;
      query[idx] = e;
      if (!last && idx < DIM - 1) begin
         elem_pos = idx + 1;
         return;
      end
      elem_pos = 0;
      for (int i = 0; i < used_cnt; i++) begin
         s = cosine_to(i);
         if (i == 0 || s > best) begin
            best = s;
            slot = i;
         end
      end
      resid = used_cnt == 0 ? 17'd32768 : 17'(32768 - best);
      add = used_cnt == 0 || resid > threshold;
      if (add) begin
         lim = entry_limit;
         if (lim < 1) lim = 1;
         if (lim > ENTRIES) lim = ENTRIES;
         if (used_cnt >= lim) begin
            oldest = stamps[0];
            slot = 0;
            for (int i = 1; i < used_cnt; i++) begin
               if (stamps[i] < oldest) begin
                  oldest = stamps[i];
                  slot = i;
               end
            end
         end else begin
            slot = used_cnt;
            used_cnt++;
         end
         for (int i = 0; i < DIM; i++) protos[slot][i] = query[i];
         counts[slot] = 1;
         stamps[slot] = stamp != 0 ? stamp : now;
      end else begin
         refine_slot(slot);
         stamps[slot] = now;
         if (counts[slot] < 16'hFFFF) counts[slot]++;
      end
      for (int i = 0; i < DIM; i++) begin
         w.element = protos[slot][i];
         w.final_res = i == DIM - 1;
         w.action = !add;
         w.slot = slot[7:0];
         w.residual = resid;
         proto_out_q.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      proto_word_t w;
      if (!reset && rsp_strobe) begin
         if (proto_out_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer");
         end else begin
            w = proto_out_q.pop_front();
            if (rsp_proto_element !== w.element || rsp_final_res !== w.final_res ||
                rsp_action !== w.action || rsp_slot !== w.slot ||
                rsp_residual !== w.residual) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp elem %0d fin %0b act %0b slot %0d res %0d, ",
                           w.element, w.final_res, w.action, w.slot, w.residual,
                           "got elem %0d fin %0b act %0b slot %0d res %0d",
                           rsp_proto_element, rsp_final_res, rsp_action, rsp_slot,
                           rsp_residual);
            end
         end
      end
   end

   task automatic write_csr(logic [3:0] index, logic [16:0] data);
      bit rdy;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do begin
         @(posedge clock);
         rdy = csr_ready;
         @(negedge clock);
      end while (!rdy);
      if (index == CSR_ADD_THRESHOLD) threshold = data;
      else if (index == CSR_MAX_ENTRIES) entry_limit = data[8:0];
      csr_valid <= 1'b0;
   endtask

   task automatic send_element(logic signed [15:0] e, logic last,
                               logic [39:0] stamp, logic [39:0] now);
      bit b;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start <= 1'b1;
      req_element <= e;
      req_last <= last;
      req_stamp <= stamp;
      req_now <= now;
      do begin
         b = busy;
         @(posedge clock);
         if (!b) cluster_step(e, last, stamp, now);
         @(negedge clock);
      end while (b);
      elements_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (proto_out_q.size() != 0 || busy) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [39:0] rand40();
      return {8'($urandom), 32'($urandom)};
   endfunction

   task automatic send_query(int len, int base, int noise, bit zero_stamp);
      int v;
      for (int i = 0; i < len; i++) begin
         v = base < 0 ? int'($urandom_range(0, 65535)) - 32768 :
             int'(bases[base][i]) + int'($urandom_range(0, 2 * noise)) - noise;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         send_element(16'(v), i == len - 1 && len < DIM, zero_stamp ? 40'd0 : rand40(),
                      rand40());
      end
   endtask

   task automatic test_directed();
      idle_on = 1'b0;
      write_csr(CSR_MAX_ENTRIES, 17'd4);
      send_element(16'sh7FFF, 1'b0, 40'hFF_FFFF_FFFF, 40'h1);
      send_element(-16'sd32768, 1'b1, 40'h0, 40'h12_3456_789A);
      send_element(-16'sd32768, 1'b0, 40'h5, 40'h6);
      send_element(16'sh7FFF, 1'b1, 40'h5, 40'h6);
      send_element(16'sd0, 1'b1, 40'h3, 40'h7);
      send_element(16'sd0, 1'b0, 40'h0, 40'hFF_FFFF_FFFF);
      send_element(16'sd0, 1'b1, 40'h0, 40'hFF_FFFF_FFFF);
      send_query(DIM, 0, 0, 1'b0);
      send_element(16'sh4000, 1'b1, 40'h2, 40'h9);
      wait_drained();
      write_csr(CSR_ADD_THRESHOLD, 17'd0);
      write_csr(CSR_MAX_ENTRIES, 17'd0);
      send_element(16'sh1234, 1'b1, 40'h8, 40'h8);
      send_element(-16'sd77, 1'b1, 40'h0, 40'h9);
      wait_drained();
      write_csr(CSR_ADD_THRESHOLD, 17'h1FFFF);
      write_csr(CSR_MAX_ENTRIES, 17'd511);
      send_element(-16'sh1234, 1'b1, 40'h1, 40'h2);
      send_element(16'sh7FFF, 1'b1, 40'h1, 40'h2);
      wait_drained();
   endtask

   task automatic test_refine_mix();
      idle_on = 1'b1;
      write_csr(CSR_ADD_THRESHOLD, 17'd16384);
      write_csr(CSR_MAX_ENTRIES, 17'd6);
      while (elements_sent < 90)
         send_query($urandom_range(1, 8), int'($urandom_range(0, 4)) - 1,
                    $urandom_range(0, 3000), $urandom_range(0, 5) == 0);
      wait_drained();
   endtask

   task automatic test_refine_all();
      write_csr(CSR_ADD_THRESHOLD, 17'd65536);
      write_csr(CSR_MAX_ENTRIES, 17'd256);
      while (elements_sent < 140)
         send_query($urandom_range(2, 8), $urandom_range(0, 3), 20000, 1'b0);
      send_query(DIM, -1, 0, 1'b0);
      wait_drained();
   endtask

   task automatic test_eviction();
      write_csr(CSR_ADD_THRESHOLD, 17'd0);
      write_csr(CSR_MAX_ENTRIES, 17'd3);
      while (elements_sent < 190)
         send_query($urandom_range(1, 6), int'($urandom_range(0, 4)) - 1, 8000,
                    $urandom_range(0, 3) == 0);
      write_csr(CSR_ADD_THRESHOLD, 17'd2000);
      idle_on = 1'b0;
      while (elements_sent < 220)
         send_query($urandom_range(1, 6), $urandom_range(0, 3), 200, 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_element = '0;
      req_last = 1'b0;
      req_stamp = '0;
      req_now = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      used_cnt = 0;
      elem_pos = 0;
      threshold = 17'd16384;
      entry_limit = 9'd256;
      mismatches = 0;
      elements_sent = 0;
      idle_on = 1'b0;
      for (int k = 0; k < 4; k++)
         for (int i = 0; i < DIM; i++) bases[k][i] = 16'($urandom);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_refine_mix();
      test_refine_all();
      test_eviction();
      wait_drained();
      repeat (200) @(negedge clock);
      if (mismatches == 0 && proto_out_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
